FILE: hdl/rpnh_pkg.sv
// shared types and constants for the ray polygon nearest hit block
package rpnh_pkg;

    localparam int COORD_W = 16;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_CAST  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic REG_VERTEX_COUNT = 1'b0;
    localparam logic REG_OPAQUE       = 1'b1;

    typedef struct packed {
        logic [1:0]                 kind;
        logic [3:0]                 vertex_index;
        logic signed [COORD_W-1:0]  vertex_x;
        logic signed [COORD_W-1:0]  vertex_y;
        logic signed [COORD_W-1:0]  ray_src_x;
        logic signed [COORD_W-1:0]  ray_src_y;
        logic signed [COORD_W-1:0]  target_x;
        logic signed [COORD_W-1:0]  target_y;
    } t_in;

    typedef struct packed {
        logic                       hit;
        logic signed [COORD_W-1:0]  end_x;
        logic signed [COORD_W-1:0]  end_y;
        logic                       touched;
    } t_out;

    // control from the edge walker to the cell row
    typedef struct packed {
        logic load;
        logic shift;
    } t_row_ctl;

endpackage

FILE: hdl/rpnh_cell.sv
// one vertex cell of the rotating vertex ring
module rpnh_cell (
    input  logic                            i_clk,
    input  rpnh_pkg::t_row_ctl              i_ctl,
    input  logic                            i_wr,
    input  logic signed [rpnh_pkg::COORD_W-1:0] i_wx,
    input  logic signed [rpnh_pkg::COORD_W-1:0] i_wy,
    input  logic signed [rpnh_pkg::COORD_W-1:0] i_nx,
    input  logic signed [rpnh_pkg::COORD_W-1:0] i_ny,
    output logic signed [rpnh_pkg::COORD_W-1:0] o_x,
    output logic signed [rpnh_pkg::COORD_W-1:0] o_y
);
    import rpnh_pkg::*;

    logic signed [COORD_W-1:0] r_x, r_y;   // home copy
    logic signed [COORD_W-1:0] r_wx, r_wy; // working copy, shifts along the ring

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_x <= i_wx;
            r_y <= i_wy;
        end
        if (i_ctl.load) begin
            r_wx <= r_x;
            r_wy <= r_y;
        end else if (i_ctl.shift) begin
            r_wx <= i_nx;
            r_wy <= i_ny;
        end
    end

    assign o_x = r_wx;
    assign o_y = r_wy;
endmodule

FILE: hdl/rpnh_div.sv
// restoring divider: round(n*|a|/den) for 0 <= n <= den, |a| < 2^17
module rpnh_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [64:0] i_num,   // 2*n*|a| + den
    input  logic [63:0] i_den,   // 2*den
    output logic        o_done,
    output logic [17:0] o_q
);
    import rpnh_pkg::*;

    localparam int QW = 18;

    logic [64:0] r_rem;
    logic [63:0] r_den;
    logic [QW-1:0] r_q;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [81:0] w_trial;
    logic        w_fit;

    // quotient fits in 18 bits since n <= den
    always_comb begin
        w_trial = {18'd0, r_den} << (QW - 1 - r_cnt);
        w_fit   = ({17'd0, r_rem} >= w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= i_num;
                r_den  <= i_den;
                r_q    <= '0;
                r_cnt  <= 5'd0;
            end else if (r_busy) begin
                // quotient bits enter msb first
                r_q <= {r_q[QW-2:0], w_fit};
                if (w_fit) begin
                    r_rem <= 65'({17'd0, r_rem} - w_trial);
                end
                if (r_cnt == 5'(QW - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
                r_cnt <= r_cnt + 5'd1;
            end
        end
    end

    assign o_q = r_q;
endmodule

FILE: hdl/ray_polygon_nearest_hit.sv
// top level: vertex ring of cells, edge walker and shared divider
//  channel | direction | handshake         | payload
//  in      | input     | i_valid/o_stall   | t_in
//  out     | output    | o_valid/i_stall   | t_out
//  cfg     | input     | i_cfg_we          | i_cfg_index, i_cfg_data
// a cast walks the edges in turn; an edge that the ray crosses runs two 18-step divisions
// on the shared divider, x then y; writes and clears skip the walk and go to ST_OUT
// the next item is taken in the cycle after the result leaves; one item is worked at a time
// reset is synchronous, active low, and sets vertex_count 3, opaque 1, touched 0
// a waiting result sits in the output register while o_stall holds back new items
module ray_polygon_nearest_hit #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  rpnh_pkg::t_in        i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output rpnh_pkg::t_out       o_data,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [4:0]           i_cfg_data
);
    import rpnh_pkg::*;

    localparam int CW = COORD_W;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_LOAD  = 4'd1;
    localparam logic [3:0] ST_MUL   = 4'd2;
    localparam logic [3:0] ST_CROSS = 4'd3;
    localparam logic [3:0] ST_TEST  = 4'd4;
    localparam logic [3:0] ST_DIVX  = 4'd5;
    localparam logic [3:0] ST_DIVY  = 4'd6;
    localparam logic [3:0] ST_SQ    = 4'd7;
    localparam logic [3:0] ST_CMP   = 4'd8;
    localparam logic [3:0] ST_NEXT  = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;

    logic [3:0]  r_state;
    logic [4:0]  r_vcount;
    logic        r_opaque;
    logic        r_touched;
    t_in         r_item;
    logic [8:0]  r_edge, r_nedges;
    logic        r_ovalid;
    t_out        r_out;
    logic        r_hit;
    logic signed [CW-1:0] r_cx, r_cy, r_hx, r_hy;

    // multiplier products
    logic signed [35:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic signed [37:0] r_den, r_n1, r_n2;
    logic signed [37:0] r_sqh;

    // cell row
    t_row_ctl w_ctl;
    logic signed [CW-1:0] w_x [MAX_VERTICES];
    logic signed [CW-1:0] w_y [MAX_VERTICES];
    logic w_accept, w_wr;
    logic [8:0] w_cnt;

    assign w_accept = i_valid && !o_stall;
    assign w_wr = w_accept && i_data.kind == KIND_WRITE &&
                  9'(i_data.vertex_index) < 9'(MAX_VERTICES);
    assign w_cnt = (9'(r_vcount) > 9'(MAX_VERTICES)) ? 9'(MAX_VERTICES) : 9'(r_vcount);

    genvar g;
    generate
        for (g = 0; g < MAX_VERTICES; g++) begin : g_cell
            rpnh_cell u_cell (
                .i_clk (i_clk),
                .i_ctl (w_ctl),
                .i_wr  (w_wr && 32'(i_data.vertex_index) == g),
                .i_wx  (i_data.vertex_x),
                .i_wy  (i_data.vertex_y),
                .i_nx  (w_x[(g + 1) % MAX_VERTICES]),
                .i_ny  (w_y[(g + 1) % MAX_VERTICES]),
                .o_x   (w_x[g]),
                .o_y   (w_y[g])
            );
        end
    endgenerate

    // edge i uses cell 0 (vertex i) and the wrap vertex: cell 1 unless last edge
    logic signed [CW-1:0] r_qx, r_qy, r_vx0, r_vy0;
    logic signed [CW:0] w_dx, w_dy, w_ex, w_ey, w_wx, w_wy;
    assign w_dx = 17'(r_item.target_x) - 17'(r_item.ray_src_x);
    assign w_dy = 17'(r_item.target_y) - 17'(r_item.ray_src_y);
    assign w_ex = 17'(r_qx) - 17'(w_x[0]);
    assign w_ey = 17'(r_qy) - 17'(w_y[0]);
    assign w_wx = 17'(w_x[0]) - 17'(r_item.ray_src_x);
    assign w_wy = 17'(w_y[0]) - 17'(r_item.ray_src_y);

    // the next-neighbor look in ST_NEXT uses values before the shift lands,
    // so the far end of the next edge still sits two cells up
    logic signed [CW-1:0] w_nqx, w_nqy;
    assign w_nqx = (r_edge + 9'd2 == r_nedges) ? r_vx0 : w_x[2 % MAX_VERTICES];
    assign w_nqy = (r_edge + 9'd2 == r_nedges) ? r_vy0 : w_y[2 % MAX_VERTICES];

    // divider
    logic        r_dstart, w_ddone;
    logic [64:0] r_dnum;
    logic [63:0] r_dden;
    logic [17:0] w_q;
    rpnh_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_num(r_dnum), .i_den(r_dden), .o_done(w_ddone), .o_q(w_q)
    );

    logic signed [37:0] w_adn, w_n1a, w_n2a;
    assign w_adn = r_den[37] ? -r_den : r_den;
    assign w_n1a = r_den[37] ? -r_n1 : r_n1;
    assign w_n2a = r_den[37] ? -r_n2 : r_n2;

    // divider numerator for one axis
    function automatic logic [64:0] f_num(input logic signed [37:0] n,
                                          input logic signed [CW:0] a,
                                          input logic signed [37:0] d);
        logic [16:0] mag;
        mag = a[CW] ? 17'(-a) : 17'(a);
        return 65'({27'd0, n} * {48'd0, mag} * 65'd2) + 65'(d);
    endfunction

    // saturate s + signed q
    function automatic logic signed [CW-1:0] f_sat(input logic signed [CW-1:0] s,
                                                   input logic neg,
                                                   input logic [17:0] q);
        logic signed [19:0] v;
        v = 20'(s) + (neg ? -20'({2'b0, q}) : 20'({2'b0, q}));
        if (v > 20'sd32767) return 16'sh7fff;
        if (v < -20'sd32768) return 16'sh8000;
        return v[CW-1:0];
    endfunction

    logic signed [CW:0] w_ox, w_oy, w_ax, w_ay;
    assign w_ox = 17'(r_hx) - 17'(r_item.ray_src_x);
    assign w_oy = 17'(r_hy) - 17'(r_item.ray_src_y);
    assign w_ax = 17'(r_cx) - 17'(r_item.ray_src_x);
    assign w_ay = 17'(r_cy) - 17'(r_item.ray_src_y);

    always_comb begin
        w_ctl.load  = (r_state == ST_LOAD);
        w_ctl.shift = (r_state == ST_NEXT);
    end

    assign o_stall = (r_state != ST_IDLE) || r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_vcount  <= 5'd3;
            r_opaque  <= 1'b1;
            r_touched <= 1'b0;
            r_ovalid  <= 1'b0;
            r_dstart  <= 1'b0;
        end else begin
            r_dstart <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_index == REG_VERTEX_COUNT) r_vcount <= i_cfg_data;
                else r_opaque <= i_cfg_data[0];
            end
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_item <= i_data;
                        r_hit  <= 1'b0;
                        r_cx   <= i_data.target_x;
                        r_cy   <= i_data.target_y;
                        if (i_data.kind == KIND_CAST) begin
                            r_state <= ST_LOAD;
                        end else begin
                            if (i_data.kind == KIND_CLEAR) r_touched <= 1'b0;
                            r_state <= ST_OUT;
                        end
                    end
                end
                ST_LOAD: begin
                    r_edge   <= 9'd0;
                    r_nedges <= w_cnt;
                    r_state  <= (w_cnt == 9'd0) ? ST_OUT : ST_MUL;
                end
                ST_MUL: begin
                    if (r_edge == 9'd0) begin
                        r_vx0 <= w_x[0];
                        r_vy0 <= w_y[0];
                    end
                    r_qx <= (r_nedges == 9'd1) ? w_x[0] : w_x[1 % MAX_VERTICES];
                    r_qy <= (r_nedges == 9'd1) ? w_y[0] : w_y[1 % MAX_VERTICES];
                    r_state <= ST_CROSS;
                end
                ST_CROSS: begin
                    r_p0 <= 36'(w_dx * w_ey);
                    r_p1 <= 36'(w_dy * w_ex);
                    r_p2 <= 36'(w_wx * w_ey);
                    r_p3 <= 36'(w_wy * w_ex);
                    r_p4 <= 36'(w_wx * w_dy);
                    r_p5 <= 36'(w_wy * w_dx);
                    r_state <= ST_TEST;
                end
                ST_TEST: begin
                    r_den <= 38'(r_p0) - 38'(r_p1);
                    r_n1  <= 38'(r_p2) - 38'(r_p3);
                    r_n2  <= 38'(r_p4) - 38'(r_p5);
                    r_state <= ST_DIVX;
                    r_sqh <= '0;
                end
                ST_DIVX: begin
                    // first cycle here: validity test and launch x division
                    if (r_sqh == '0) begin
                        if (r_den == '0 || w_n1a < 0 || w_n1a > w_adn ||
                            w_n2a < 0 || w_n2a > w_adn) begin
                            r_state <= ST_NEXT;
                        end else begin
                            r_dnum   <= f_num(w_n1a, w_dx, w_adn);
                            r_dden   <= 64'(w_adn) << 1;
                            r_dstart <= 1'b1;
                            r_sqh    <= 38'sd1;
                        end
                    end else if (w_ddone) begin
                        r_hx     <= f_sat(r_item.ray_src_x, w_dx[CW], w_q);
                        r_dnum   <= f_num(w_n1a, w_dy, w_adn);
                        r_dstart <= 1'b1;
                        r_state  <= ST_DIVY;
                    end
                end
                ST_DIVY: begin
                    if (w_ddone) begin
                        r_hy    <= f_sat(r_item.ray_src_y, w_dy[CW], w_q);
                        r_state <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    r_p0 <= 36'(w_ox * w_ox);
                    r_p1 <= 36'(w_oy * w_oy);
                    r_p2 <= 36'(w_ax * w_ax);
                    r_p3 <= 36'(w_ay * w_ay);
                    r_state <= ST_CMP;
                end
                ST_CMP: begin
                    if ($unsigned(r_p0) + $unsigned(r_p1) <=
                        $unsigned(r_p2) + $unsigned(r_p3)) begin
                        if (r_opaque) begin
                            r_cx  <= r_hx;
                            r_cy  <= r_hy;
                            r_hit <= 1'b1;
                        end else begin
                            r_touched <= 1'b1;
                        end
                    end
                    r_state <= ST_NEXT;
                end
                ST_NEXT: begin
                    // ring rotates by one as this state ends: the next vertex then sits in cell 0
                    r_qx <= w_nqx;
                    r_qy <= w_nqy;
                    r_edge <= r_edge + 9'd1;
                    r_state <= (r_edge + 9'd1 == r_nedges) ? ST_OUT : ST_CROSS;
                end
                ST_OUT: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && (!r_ovalid || !i_stall)) begin
            r_out.hit     <= r_hit;
            r_out.end_x   <= (r_item.kind == KIND_CAST) ? r_cx : '0;
            r_out.end_y   <= (r_item.kind == KIND_CAST) ? r_cy : '0;
            r_out.touched <= r_touched;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;
endmodule

FILE: hdl/rpnh_checker.sv
// port-level checks for the ray polygon nearest hit block
module rpnh_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           o_stall,
    input logic           o_valid,
    input logic           i_stall,
    input rpnh_pkg::t_out o_data
);
    import rpnh_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("output changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while result waits");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second transaction taken while one is in work");
endmodule

bind ray_polygon_nearest_hit rpnh_checker u_rpnh_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
);
